>>> design/assert_macros.svh
// Assertion macros shared by the closest-point block.
// Used by the controller and the datapath; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication: when a holds, b holds at the next clock.
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");

// Same-cycle implication.
`define ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle check failed");

`endif

>>> design/cpp_pkg.sv
// Package for the closest-point block: constants, FSM states, command/status.
// No dependencies.
package cpp_pkg;

  localparam int ABS_BITS         = 16;
  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_TERMS        = 8;
  localparam logic [15:0] STEP_RESET = 16'd655;
  localparam logic [16:0] ABS_ONE    = 17'h10000;

  typedef enum logic {
    REG_SEGMENT_COUNT = 1'b0,
    REG_STEP_SIZE     = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_MUL,
    ST_ACC,
    ST_DIFF,
    ST_SQ,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic mem_wr;
    logic start_query;
    logic mul;
    logic acc;
    logic diff;
    logic sq;
    logic cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic none;
    logic term_last;
    logic sample_last;
    logic seg_last;
    logic out_busy;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) r = v[31:0];
    else if (v[33]) r = 32'sh8000_0000;
    else r = 32'sh7FFF_FFFF;
    return r;
  endfunction

endpackage

>>> design/closest_point_on_poly_path_unit.sv
// Top level of the closest-point-on-polynomial-path block: config registers,
// controller and datapath. Depends on cpp_pkg, cpp_ctrl, cpp_datapath.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_stall + operation..query_y    | item in
//  out     | out_valid/out_stall + found, best_*       | item out
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata   | APB regs
//
// A load item is written in the cycle that accepts it. A query sweeps
// count * ceil(65536/step) samples; each runs ADDR, MUL and ACC per term, then
// DIFF, SQ and CMP, and DONE loads the output register. count is capped at
// MAX_SEGMENTS and a zero step acts as one. The time is set by the per-term
// read/multiply/accumulate loop through one shared multiplier pair and the
// coefficient memory read port.
// Reset is synchronous, active low; coefficient memories are not cleared.
// A result waits in the output register; the next item is taken meanwhile
// unless a query finishes while the previous result is still stalled.
module closest_point_on_poly_path_unit
  import cpp_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int TERMS        = DEF_TERMS
) (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [5:0]         in_segment_sel,
  input  logic [2:0]         in_term_sel,
  input  logic               in_axis_sel,
  input  logic signed [31:0] in_coef_value,
  input  logic signed [31:0] in_query_x,
  input  logic signed [31:0] in_query_y,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic [5:0]         out_best_segment,
  output logic [15:0]        out_best_abscissa,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [6:0]  seg_count_r;
  logic [15:0] step_size_r;
  logic        reg_wr;
  reg_idx_t    reg_sel;
  cmd_t        cmd;
  status_t     status;

  // byte address: bit 2 picks the register
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= '0;
      step_size_r <= STEP_RESET;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_SEGMENT_COUNT: seg_count_r <= pwdata[6:0];
        REG_STEP_SIZE:     step_size_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SEGMENT_COUNT: prdata = {25'd0, seg_count_r};
      REG_STEP_SIZE:     prdata = {16'd0, step_size_r};
      default:           prdata = '0;
    endcase
  end

  cpp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .status       (status),
    .cmd          (cmd)
  );

  cpp_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .TERMS        (TERMS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_segment_sel    (in_segment_sel),
    .in_term_sel       (in_term_sel),
    .in_axis_sel       (in_axis_sel),
    .in_coef_value     (in_coef_value),
    .in_query_x        (in_query_x),
    .in_query_y        (in_query_y),
    .cfg_segment_count (seg_count_r),
    .cfg_step_size     (step_size_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_best_segment  (out_best_segment),
    .out_best_abscissa (out_best_abscissa)
  );

endmodule

>>> design/cpp_ctrl.sv
// Controller FSM of the closest-point block: sequences loads, polynomial terms,
// distance and compare steps. Depends on cpp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cpp_ctrl
  import cpp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_operation,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_LOAD) begin
            cmd.mem_wr = 1'b1;
          end else begin
            cmd.start_query = 1'b1;
            state_nxt = status.none ? ST_DONE : ST_ADDR;
          end
        end
      end
      ST_ADDR: state_nxt = ST_MUL;
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = status.term_last ? ST_DIFF : ST_ADDR;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = (status.sample_last && status.seg_last) ? ST_DONE : ST_ADDR;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_load_stays_idle, state_r == ST_IDLE && in_valid && in_operation == OP_LOAD, state_r == ST_IDLE)
  `ASSERT_NEXT(a_term_loops, state_r == ST_ACC && !status.term_last, state_r == ST_ADDR)
  `ASSERT_NEXT(a_sweep_ends, state_r == ST_CMP && status.sample_last && status.seg_last, state_r == ST_DONE)

endmodule

>>> design/cpp_datapath.sv
// Datapath of the closest-point block: coefficient memories, term multiply,
// saturating accumulate, squared distance, best tracking, output register.
// Depends on cpp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cpp_datapath
  import cpp_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int TERMS        = DEF_TERMS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [5:0]         in_segment_sel,
  input  logic [2:0]         in_term_sel,
  input  logic               in_axis_sel,
  input  logic signed [31:0] in_coef_value,
  input  logic signed [31:0] in_query_x,
  input  logic signed [31:0] in_query_y,
  input  logic [6:0]         cfg_segment_count,
  input  logic [15:0]        cfg_step_size,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic [5:0]         out_best_segment,
  output logic [15:0]        out_best_abscissa
);

  localparam int DEPTH = MAX_SEGMENTS * TERMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SEGW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int TW    = $clog2(TERMS);
  localparam int CNTW  = $clog2(MAX_SEGMENTS + 1);

  logic signed [31:0] mem_x [DEPTH];
  logic signed [31:0] mem_y [DEPTH];
  logic signed [31:0] rdx_r, rdy_r;

  logic [SEGW-1:0]    seg_r;
  logic [TW-1:0]      term_r;
  logic [15:0]        s_r;
  logic [16:0]        p_r, pnext_r;
  logic signed [48:0] prod_x_r, prod_y_r;
  logic signed [31:0] acc_x_r, acc_y_r;
  logic signed [31:0] qx_r, qy_r;
  logic [31:0]        mag_x_r, mag_y_r;
  logic [63:0]        sqx_r, sqy_r;
  logic [64:0]        best_d_r;
  logic               have_r;
  logic [SEGW-1:0]    best_seg_r;
  logic [15:0]        best_s_r;
  logic               out_valid_r;
  logic               out_found_r;
  logic [5:0]         out_seg_r;
  logic [15:0]        out_abs_r;

  logic               wr_ok;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [CNTW-1:0]    cnt_eff;
  logic [15:0]        step_eff;
  logic [16:0]        s_next;
  logic signed [48:0] prod_x_nxt, prod_y_nxt;
  logic [32:0]        pw_full;
  logic signed [33:0] sum_x, sum_y, dif_x, dif_y;
  logic signed [31:0] dx, dy;
  logic [64:0]        dist_sum;
  logic               better;

  assign wr_ok   = (32'(in_segment_sel) < 32'(MAX_SEGMENTS)) && (32'(in_term_sel) < 32'(TERMS));
  assign wr_addr = AW'(32'(in_segment_sel) * 32'(TERMS) + 32'(in_term_sel));
  assign rd_addr = AW'(32'(seg_r) * 32'(TERMS) + 32'(term_r));
  assign cnt_eff = (32'(cfg_segment_count) > 32'(MAX_SEGMENTS)) ? CNTW'(MAX_SEGMENTS)
                                                                 : CNTW'(cfg_segment_count);
  assign step_eff = (cfg_step_size == 16'd0) ? 16'd1 : cfg_step_size;
  assign s_next   = {1'b0, s_r} + {1'b0, step_eff};

  assign prod_x_nxt = rdx_r * $signed({1'b0, p_r});
  assign prod_y_nxt = rdy_r * $signed({1'b0, p_r});
  assign pw_full    = p_r * s_r;
  // floor(c*p / 2^16) is the arithmetic top slice of the product
  assign sum_x = {{2{acc_x_r[31]}}, acc_x_r} + {prod_x_r[48], prod_x_r[48:16]};
  assign sum_y = {{2{acc_y_r[31]}}, acc_y_r} + {prod_y_r[48], prod_y_r[48:16]};
  assign dif_x = {{2{acc_x_r[31]}}, acc_x_r} - {{2{qx_r[31]}}, qx_r};
  assign dif_y = {{2{acc_y_r[31]}}, acc_y_r} - {{2{qy_r[31]}}, qy_r};
  assign dx    = sat32(dif_x);
  assign dy    = sat32(dif_y);
  assign dist_sum = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign better   = !have_r || (dist_sum < best_d_r);

  assign status.none        = (cnt_eff == '0);
  assign status.term_last   = (term_r == TW'(TERMS - 1));
  assign status.sample_last = s_next[16];
  assign status.seg_last    = (32'(seg_r) + 32'd1 >= 32'(cnt_eff));
  assign status.out_busy    = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && wr_ok) begin
      if (in_axis_sel) mem_y[wr_addr] <= in_coef_value;
      else mem_x[wr_addr] <= in_coef_value;
    end
    rdx_r <= mem_x[rd_addr];
    rdy_r <= mem_y[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      qx_r       <= in_query_x;
      qy_r       <= in_query_y;
      seg_r      <= '0;
      s_r        <= '0;
      term_r     <= '0;
      acc_x_r    <= '0;
      acc_y_r    <= '0;
      p_r        <= ABS_ONE;
      best_seg_r <= '0;
      best_s_r   <= '0;
    end
    if (cmd.mul) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      pnext_r  <= pw_full[32:16];
    end
    if (cmd.acc) begin
      acc_x_r <= sat32(sum_x);
      acc_y_r <= sat32(sum_y);
      p_r     <= pnext_r;
      if (!status.term_last) term_r <= term_r + 1'b1;
    end
    if (cmd.diff) begin
      mag_x_r <= dx[31] ? (~dx + 32'd1) : dx;
      mag_y_r <= dy[31] ? (~dy + 32'd1) : dy;
    end
    if (cmd.sq) begin
      sqx_r <= mag_x_r * mag_x_r;
      sqy_r <= mag_y_r * mag_y_r;
    end
    if (cmd.cmp) begin
      if (better) begin
        best_d_r   <= dist_sum;
        best_seg_r <= seg_r;
        best_s_r   <= s_r;
      end
      term_r  <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
      p_r     <= ABS_ONE;
      if (status.sample_last) begin
        s_r   <= '0;
        seg_r <= seg_r + 1'b1;
      end else begin
        s_r <= s_next[15:0];
      end
    end
    if (cmd.out_load) begin
      out_found_r <= have_r;
      out_seg_r   <= 6'(best_seg_r);
      out_abs_r   <= best_s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start_query) have_r <= 1'b0;
      else if (cmd.cmp) have_r <= 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_best_segment  = out_seg_r;
  assign out_best_abscissa = out_abs_r;

  `ASSERT_NEXT(a_cmp_sets_have, cmd.cmp, have_r)
  `ASSERT_NOW(a_load_when_free, cmd.out_load, !(out_valid_r && out_stall))

endmodule

>>> tb/cpp_checker.sv
// Scoreboard for the closest-point block: mirrors registers and coefficient
// tables, predicts each query result and compares. Depends on cpp_pkg.
module cpp_checker
  import cpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_operation,
  input  logic [5:0]         in_segment_sel,
  input  logic [2:0]         in_term_sel,
  input  logic               in_axis_sel,
  input  logic signed [31:0] in_coef_value,
  input  logic signed [31:0] in_query_x,
  input  logic signed [31:0] in_query_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_found,
  input  logic [5:0]         out_best_segment,
  input  logic [15:0]        out_best_abscissa,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic        found;
    logic [5:0]  seg;
    logic [15:0] abscissa;
  } nearest_t;

  logic signed [31:0] x_coef [512];
  logic signed [31:0] y_coef [512];
  logic [6:0]  seg_count;
  logic [15:0] step_q16;
  nearest_t    nearest_q[$];

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // x(s) or y(s) in Q16.16; power chain truncates, each term floors
  function automatic longint poly_at(input int base, input logic ax, input int s);
    longint acc, p, c;
    acc = 0;
    p = 65536;
    for (int i = 0; i < DEF_TERMS; i++) begin
      if (i > 0) p = (p * s) >> ABS_BITS;
      c = ax ? y_coef[base + i] : x_coef[base + i];
      acc = clip32(acc + ((c * p) >>> ABS_BITS));
    end
    return acc;
  endfunction

  function automatic longint unsigned dist_sq(input longint v, input longint q);
    longint d;
    d = clip32(v - q);
    if (d < 0) d = -d;
    return longint'(d) * longint'(d);
  endfunction

  function automatic nearest_t find_nearest(input logic signed [31:0] qx,
                                            input logic signed [31:0] qy);
    nearest_t r;
    int cnt, stp;
    longint unsigned d, best;
    r = '0;
    best = 0;
    cnt = (seg_count > DEF_MAX_SEGMENTS) ? DEF_MAX_SEGMENTS : seg_count;
    stp = (step_q16 == 0) ? 1 : step_q16;
    for (int sg = 0; sg < cnt; sg++)
      for (int s = 0; s < 65536; s += stp) begin
        d = dist_sq(poly_at(sg * DEF_TERMS, 1'b0, s), qx)
          + dist_sq(poly_at(sg * DEF_TERMS, 1'b1, s), qy);
        // strict less keeps the earliest sample on ties
        if (!r.found || d < best) begin
          r.found = 1'b1;
          best = d;
          r.seg = sg[5:0];
          r.abscissa = s[15:0];
        end
      end
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    nearest_t e;
    if (!rst_n) begin
      seg_count = 7'd0;
      step_q16 = STEP_RESET;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_t'(paddr[2]) == REG_SEGMENT_COUNT) seg_count = pwdata[6:0];
        else step_q16 = pwdata[15:0];
      end
      if (out_valid && !out_stall) begin
        if (nearest_q.size() == 0) begin
          $error("result with no query outstanding");
          errors++;
        end else begin
          e = nearest_q.pop_front();
          if (out_found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, out_found);
            errors++;
          end
          if (out_best_segment !== e.seg) begin
            $error("best_segment: expected %0d, got %0d", e.seg, out_best_segment);
            errors++;
          end
          if (out_best_abscissa !== e.abscissa) begin
            $error("best_abscissa: expected %0d, got %0d", e.abscissa,
                   out_best_abscissa);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (op_t'(in_operation) == OP_LOAD) begin
          if (in_axis_sel) y_coef[{in_segment_sel, in_term_sel}] = in_coef_value;
          else x_coef[{in_segment_sel, in_term_sel}] = in_coef_value;
        end else begin
          nearest_q.insert(nearest_q.size(), find_nearest(in_query_x, in_query_y));
        end
      end
    end
    pending = nearest_q.size();
  end

endmodule

>>> tb/tb.sv
// Top of the closest-point regression: clock, reset, stimulus and verdict.
// Depends on cpp_pkg, closest_point_on_poly_path_unit and cpp_checker.
module tb;
  import cpp_pkg::*;

  localparam int STALL_LIMIT = 8000000;  // step of zero sweeps 65536 samples
  localparam int HOLD_CYCLES = 3000;
  localparam int USED_SEGS   = 4;        // segments loaded and searched

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_operation = 1'b0;
  logic [5:0]         in_segment_sel = '0;
  logic [2:0]         in_term_sel = '0;
  logic               in_axis_sel = 1'b0;
  logic signed [31:0] in_coef_value = '0;
  logic signed [31:0] in_query_x = '0;
  logic signed [31:0] in_query_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic               out_found;
  logic [5:0]         out_best_segment;
  logic [15:0]        out_best_abscissa;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int  errors, pending;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic hold_req = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  closest_point_on_poly_path_unit u_top (.*);

  cpp_checker u_chk (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: random stall, or a long hold-off so the block backs up.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog: any handshake on any port resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("closest_point_on_poly_path_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item; returns at the edge that accepted it, valid still high.
  task automatic offer(input op_t op, input logic [5:0] sg, input logic [2:0] tm,
                       input logic ax, input logic signed [31:0] cv,
                       input logic signed [31:0] qx, input logic signed [31:0] qy);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_operation   <= op;
    in_segment_sel <= sg;
    in_term_sel    <= tm;
    in_axis_sel    <= ax;
    in_coef_value  <= cv;
    in_query_x     <= qx;
    in_query_y     <= qy;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_coef(input logic [5:0] sg, input logic [2:0] tm,
                           input logic ax, input logic signed [31:0] cv);
    offer(OP_LOAD, sg, tm, ax, cv, $urandom, $urandom);
  endtask

  task automatic query(input logic signed [31:0] qx, input logic signed [31:0] qy);
    offer(OP_QUERY, 6'($urandom), 3'($urandom), 1'($urandom), $urandom, qx, qy);
  endtask

  // Registers change only with nothing in flight.
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(input logic [6:0] cnt, input logic [15:0] stp);
    drain();
    reg_write(REG_SEGMENT_COUNT, {25'd0, cnt});
    reg_write(REG_STEP_SIZE, {16'd0, stp});
  endtask

  function automatic logic signed [31:0] rand_coef;
    return $signed($urandom) >>> $urandom_range(0, 22);
  endfunction

  function automatic logic signed [31:0] rand_point;
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom) >>> $urandom_range(8, 20);
  endfunction

  // Mostly a few segments; now and then all loaded segments with a coarse step, or none.
  task automatic random_regs;
    logic [6:0]  cnt;
    logic [15:0] stp;
    case ($urandom_range(0, 9))
      0: begin
        cnt = 7'(USED_SEGS);
        stp = 16'($urandom_range(32768, 65535));
      end
      1: begin
        cnt = 7'd0;
        stp = 16'($urandom);
      end
      default: begin
        cnt = 7'($urandom_range(1, USED_SEGS));
        stp = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(600, 65535))
                                          : 16'(16'd1 << $urandom_range(10, 15));
      end
    endcase
    set_regs(cnt, stp);
  endtask

  task automatic random_items(input int n);
    repeat (n) begin
      if ($urandom_range(0, 1) != 0) query(rand_point(), rand_point());
      else load_coef(6'($urandom), 3'($urandom), 1'($urandom), rand_coef());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no segments in use: not-found result
    set_regs(7'd0, 16'hFFFF);
    query(32'sh7FFF_FFFF, 32'sh8000_0000);

    // fill every searched segment so no query reads an unwritten coefficient;
    // segment 1 stays all zero for the tie cases
    for (int sg = 0; sg < USED_SEGS; sg++)
      for (int tm = 0; tm < DEF_TERMS; tm++)
        for (int ax = 0; ax < 2; ax++)
          load_coef(6'(sg), 3'(tm), 1'(ax), (sg == 1) ? 32'sd0 : rand_coef());
    // coefficient extremes, forcing saturation in segment 0
    load_coef(6'd0, 3'd0, 1'b0, 32'sh7FFF_FFFF);
    load_coef(6'd0, 3'd7, 1'b1, 32'sh8000_0000);
    load_coef(6'd0, 3'd1, 1'b0, 32'sh7FFF_FFFF);

    set_regs(7'd1, 16'hFFFF);
    query(32'sh8000_0000, 32'sh7FFF_FFFF);
    query(32'sh7FFF_FFFF, 32'sh8000_0000);
    query(32'sh0, 32'sh0);
    // segment 1 is flat at the origin: ties across samples and segments
    set_regs(7'd2, 16'd16384);
    query(32'sh0, 32'sh0);
    query(32'sh0001_0000, -32'sh0001_0000);
    // zero step behaves as one: a single full sweep
    set_regs(7'd1, 16'd0);
    query(32'sh0000_8000, -32'sh0000_8000);
    set_regs(7'd3, STEP_RESET);
    query(rand_point(), rand_point());

    // sender 19% / receiver 60%, then swapped, then no idling
    send_idle_pct = 19;
    recv_idle_pct = 60;
    repeat (4) begin
      random_regs();
      random_items(3);
    end
    send_idle_pct = 60;
    recv_idle_pct = 19;
    repeat (4) begin
      random_regs();
      random_items(3);
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long receiver hold-off while short queries keep arriving
    set_regs(7'd1, 16'hFFFF);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (6) query(rand_point(), rand_point());
    repeat (3) begin
      random_regs();
      random_items(3);
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("closest_point_on_poly_path_unit regression: pass");
    end else begin
      $display("closest_point_on_poly_path_unit regression: fail");
    end
    $finish;
  end

endmodule
